/* sv/phpa_pkg.sv */
// Shared constants, types and helpers of the periodic halo pad addresser.
`timescale 1ns / 1ps

package phpa_pkg;

  // Tile geometry and word size.
  localparam int MaxRows  = 64;
  localparam int MaxCols  = 64;
  localparam int WordBits = 64;

  // Fixed field widths of the stream and configuration ports.
  localparam int RegW     = 7;
  localparam int CoordW   = 8;
  localparam int DataW    = 64;
  localparam int StatusW  = 2;
  localparam int InTdataW  = 80;   // row, col, data_in
  localparam int OutTdataW = 72;   // data_out, status, zero fill

  // Arithmetic width: holds coordinates, sizes, twice a halo and the size limits.
  localparam int CalcW    = 12;

  localparam int RowIdxW  = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int ColIdxW  = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int Depth    = MaxRows * MaxCols;
  localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;

  typedef logic [CalcW-1:0] calc_t;
  typedef logic [AddrW-1:0] addr_t;

  typedef enum logic {
    OpWrite = 1'b0,
    OpRead  = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk    = 2'd0,
    StatusRange = 2'd1,
    StatusHalo  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RegRows     = 2'd0,
    RegCols     = 2'd1,
    RegHaloRows = 2'd2,
    RegHaloCols = 2'd3
  } reg_idx_e;

  // Saturates a size register to the range 1..max.
  function automatic calc_t clamp_size(logic [RegW-1:0] v, int max);
    calc_t vx;
    calc_t mx;
    vx = CalcW'(v);
    mx = CalcW'(max);
    if (v == '0) begin
      return CalcW'(1);
    end else if (vx > mx) begin
      return mx;
    end
    return vx;
  endfunction

endpackage

/* sv/phpa_unwrap.sv */
// Folds one padded coordinate back into the tile for a periodic halo.
`timescale 1ns / 1ps

module phpa_unwrap (
  input  phpa_pkg::calc_t p_i,   // padded coordinate, known below 2h + n
  input  phpa_pkg::calc_t n_i,   // tile size in use
  input  phpa_pkg::calc_t h_i,   // halo width
  output phpa_pkg::calc_t idx_o  // tile coordinate, below n
);
  import phpa_pkg::*;

  calc_t h_plus_n;

  assign h_plus_n = h_i + n_i;

  always_comb begin
    if (p_i < h_i) begin
      idx_o = n_i - h_i + p_i;          // leading halo takes the far edge
    end else if (p_i < h_plus_n) begin
      idx_o = p_i - h_i;                // body of the tile
    end else begin
      idx_o = p_i - h_plus_n;           // trailing halo takes the near edge
    end
  end

endmodule

/* sv/periodic_halo_pad_addresser_core.sv */
// Top level: tile store with periodic halo addressing on a stream interface.
`timescale 1ns / 1ps

// Periodic halo pad addresser.
//
// The slave stream carries one access per beat: tuser is the operation (write a
// tile element, or read an element of the padded tile), tdata holds row, column
// and the data word. Each accepted beat produces exactly one beat on the master
// stream with the data word and a status code. Reads wrap the padded coordinate
// back into the tile in each axis, so corners wrap in both directions.
// The configuration port sets tile size and halo widths; it must be written only
// while no access is in flight, and the block itself does not enforce this.
//
// An accepted input beat first passes the read stage, which forms the address
// and reads the tile memory into its registered read port, and then the output
// register, which takes the result. One beat is accepted every cycle while the
// receiver keeps taking beats; the single-port-per-direction tile memory sets that.
// When the receiver stalls, the output register holds its beat and the read
// stage can still take one more access; input ready falls only when both are
// full and the receiver is not taking a beat.
// Reset empties the pipeline and loads the default sizes (64 by 64, halo 1).
// The tile memory is not cleared; an entry must be written before it is read.

module periodic_halo_pad_addresser_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Access stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [phpa_pkg::InTdataW-1:0]   s_axis_tdata,  // row[7:0], col[15:8], data_in[79:16]
  input  logic                            s_axis_tuser,  // op[0]
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [phpa_pkg::OutTdataW-1:0]  m_axis_tdata,  // data_out[63:0], status[65:64], zero
  // Configuration
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [phpa_pkg::RegW-1:0]       cfg_data_i
);
  import phpa_pkg::*;

  // Configuration registers.
  logic [RegW-1:0] rows_q, cols_q, halo_rows_q, halo_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= RegW'(64);
      cols_q      <= RegW'(64);
      halo_rows_q <= RegW'(1);
      halo_cols_q <= RegW'(1);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegRows:     rows_q      <= cfg_data_i;
        RegCols:     cols_q      <= cfg_data_i;
        RegHaloRows: halo_rows_q <= cfg_data_i;
        RegHaloCols: halo_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the incoming beat.
  op_e                  in_op;
  logic [CoordW-1:0]    in_row, in_col;
  logic [WordBits-1:0]  in_word;

  assign in_op   = op_e'(s_axis_tuser);
  assign in_row  = s_axis_tdata[CoordW-1:0];
  assign in_col  = s_axis_tdata[2*CoordW-1:CoordW];
  assign in_word = s_axis_tdata[2*CoordW +: WordBits];

  // Sizes in use and the derived checks.
  calc_t nr, nc, hr, hc, pr, pc;
  logic  halo_bad, pad_out, wr_out;

  assign nr = clamp_size(rows_q, MaxRows);
  assign nc = clamp_size(cols_q, MaxCols);
  assign hr = CalcW'(halo_rows_q);
  assign hc = CalcW'(halo_cols_q);
  assign pr = CalcW'(in_row);
  assign pc = CalcW'(in_col);

  assign halo_bad = (hr > nr) || (hc > nc);
  assign pad_out  = (pr >= nr + (hr << 1)) || (pc >= nc + (hc << 1));
  assign wr_out   = (pr >= nr) || (pc >= nc);

  // Wrap the padded coordinate back into the tile.
  calc_t tile_row, tile_col;

  phpa_unwrap u_unwrap_row (
    .p_i   (pr),
    .n_i   (nr),
    .h_i   (hr),
    .idx_o (tile_row)
  );

  phpa_unwrap u_unwrap_col (
    .p_i   (pc),
    .n_i   (nc),
    .h_i   (hc),
    .idx_o (tile_col)
  );

  addr_t rd_addr, wr_addr;

  assign rd_addr = AddrW'(tile_row[RowIdxW-1:0]) * AddrW'(MaxCols)
                 + AddrW'(tile_col[ColIdxW-1:0]);
  assign wr_addr = AddrW'(in_row[RowIdxW-1:0]) * AddrW'(MaxCols)
                 + AddrW'(in_col[ColIdxW-1:0]);

  // Pipeline handshake: the read stage advances when the output register is
  // free or its beat is being taken.
  logic    s1_valid_q, out_valid_q;
  logic    s1_move, in_fire, out_load;

  assign s1_move       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = s1_valid_q && s1_move;

  // Status of the access and whether the memory word is returned.
  status_e in_status;
  logic    in_use_mem, wr_en, rd_en;

  always_comb begin
    in_status  = StatusOk;
    in_use_mem = 1'b0;
    if (in_op == OpWrite) begin
      if (wr_out) begin
        in_status = StatusRange;
      end
    end else if (halo_bad) begin
      in_status = StatusHalo;
    end else if (pad_out) begin
      in_status = StatusRange;
    end else begin
      in_use_mem = 1'b1;
    end
  end

  assign wr_en = in_fire && (in_op == OpWrite) && !wr_out;
  assign rd_en = in_fire && in_use_mem;

  // Tile memory: one write port, one registered read port.
  logic [WordBits-1:0] tile_mem_q [Depth];
  logic [WordBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tile_mem_q[wr_addr] <= in_word;
    end
    if (rd_en) begin
      rdata_q <= tile_mem_q[rd_addr];
    end
  end

  // Read stage side registers.
  status_e s1_status_q;
  logic    s1_use_mem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_status_q  <= in_status;
      s1_use_mem_q <= in_use_mem;
    end
  end

  // Output register.
  logic [DataW-1:0] out_data_q;
  status_e          out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q   <= s1_use_mem_q ? DataW'(rdata_q) : '0;
      out_status_q <= s1_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'({out_status_q, out_data_q});

endmodule

/* sv/phpa_checker.sv */
// Port-level checker for the periodic halo pad addresser, bound to the top level.
`timescale 1ns / 1ps

module phpa_port_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [phpa_pkg::OutTdataW-1:0]  m_axis_tdata
);
  import phpa_pkg::*;

  logic [StatusW-1:0] st;
  logic [DataW-1:0]   dat;

  assign st  = m_axis_tdata[DataW +: StatusW];
  assign dat = m_axis_tdata[DataW-1:0];

  // A stalled result beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (st == StatusOk || st == StatusRange || st == StatusHalo))
    else $error("undefined status code");

  // A failed access never returns data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st != StatusOk |-> dat == '0)
    else $error("data returned with error status");

  // With the output register empty the block always takes a beat.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind periodic_halo_pad_addresser_core phpa_port_checker u_phpa_checker (.*);
